FILE: design/mel_triangular_filterbank_top_macros.svh
// Assertion helpers for the filter bank checker.
`ifndef MEL_TRIANGULAR_FILTERBANK_TOP_MACROS_SVH
`define MEL_TRIANGULAR_FILTERBANK_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MTFB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("filter bank check failed");

// Next-cycle implication, disabled during reset.
`define MTFB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("filter bank check failed");

`endif

FILE: design/mtfb_pkg.sv
// ----------------------------------------------------------------------------
// mtfb_pkg
// Payload types, command/status bundles and fixed constants of the filter bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtfb_pkg;

	localparam int POWER_W  = 32;
	localparam int ENERGY_W = 48;
	localparam int EDGE_W   = 17;
	localparam int FRAC_W   = 6;
	localparam int FNUM_W   = 6;

	// Edge selector relative to the current filter
	localparam logic [1:0] EDGE_SEL_LOW  = 2'd0;
	localparam logic [1:0] EDGE_SEL_MID  = 2'd1;
	localparam logic [1:0] EDGE_SEL_HIGH = 2'd2;

	// Configuration register indexes
	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [FNUM_W-1:0]   edge_index;
		logic [EDGE_W-1:0]   edge_position;
		logic [POWER_W-1:0]  power_value;
		logic                last_bin;
	} mtfb_in_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] filter_energy;
		logic [FNUM_W-1:0]   filter_number;
		logic                last_result;
	} mtfb_out_t;

	typedef struct packed {
		logic              edge_wr;
		logic              bin_load;
		logic              edge_rd;
		logic [1:0]        edge_sel;
		logic              cap_low;
		logic              low_zero;
		logic              cap_mid;
		logic              cap_high;
		logic              eval;
		logic              mul;
		logic              div_step;
		logic              take_div;
		logic              acc_rd;
		logic              acc_wr;
		logic              emit_ld;
		logic              last_flag;
		logic              frame_clr;
		logic [FNUM_W-1:0] filt;
	} mtfb_cmd_t;

	typedef struct packed {
		logic bins_full;
		logic skip;
		logic center;
		logic div_done;
		logic out_free;
	} mtfb_stat_t;

endpackage

FILE: design/mtfb_ctrl.sv
// ----------------------------------------------------------------------------
// mtfb_ctrl
// Sequencer: edge loads, per-filter accumulate walk, frame emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtfb_ctrl import mtfb_pkg::*; #(
	parameter int MAX_FILTERS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_mode,
	input  logic       in_last,
	input  logic       cfg_valid,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	output mtfb_cmd_t  cmd,
	input  mtfb_stat_t stat
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RLO    = 4'd1;
	localparam logic [3:0] S_RMID   = 4'd2;
	localparam logic [3:0] S_RHI    = 4'd3;
	localparam logic [3:0] S_CAPH   = 4'd4;
	localparam logic [3:0] S_EVAL   = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_DIV    = 4'd7;
	localparam logic [3:0] S_ACC_RD = 4'd8;
	localparam logic [3:0] S_ACC_WR = 4'd9;
	localparam logic [3:0] S_E_RD   = 4'd10;
	localparam logic [3:0] S_E_LD   = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	localparam logic [6:0] MF7 = 7'(MAX_FILTERS);

	logic [3:0]        state_q, state_d;
	logic [FNUM_W-1:0] filt_q, filt_d;
	logic              last_q, last_d;
	logic [5:0]        first_q, count_q;
	logic [FNUM_W-1:0] lo, hi;
	logic [5:0]        n_eff;
	logic [6:0]        end7;
	logic              accept;

	// Clamp the configured range
	always_comb begin
		if (first_q == 6'd0)
			lo = 6'd1;
		else if ({1'b0, first_q} > MF7)
			lo = MF7[5:0];
		else
			lo = first_q;
		n_eff = (count_q == 6'd0) ? 6'd1 : count_q;
		end7  = {1'b0, lo} + {1'b0, n_eff} - 7'd1;
		hi    = (end7 > MF7) ? MF7[5:0] : end7[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 6'd1;
			count_q <= 6'd24;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_FIRST)
				first_q <= cfg_data;
			else
				count_q <= cfg_data;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		filt_d  = filt_q;
		last_d  = last_q;
		cmd     = '0;
		cmd.filt      = filt_q;
		cmd.last_flag = (filt_q == hi);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!in_mode) begin
						cmd.edge_wr = 1'b1;
					end else begin
						cmd.bin_load = 1'b1;
						last_d       = in_last;
						filt_d       = lo;
						if (!stat.bins_full)
							state_d = S_RLO;
						else if (in_last)
							state_d = S_E_RD;
					end
				end
			end
			S_RLO: begin
				cmd.edge_rd  = 1'b1;
				cmd.edge_sel = EDGE_SEL_LOW;
				state_d      = S_RMID;
			end
			S_RMID: begin
				cmd.edge_rd  = 1'b1;
				cmd.edge_sel = EDGE_SEL_MID;
				cmd.cap_low  = 1'b1;
				cmd.low_zero = (filt_q == 6'd1);
				state_d      = S_RHI;
			end
			S_RHI: begin
				cmd.edge_rd  = 1'b1;
				cmd.edge_sel = EDGE_SEL_HIGH;
				cmd.cap_mid  = 1'b1;
				state_d      = S_CAPH;
			end
			S_CAPH: begin
				cmd.cap_high = 1'b1;
				state_d      = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.skip) begin
					if (filt_q == hi) begin
						filt_d  = lo;
						state_d = last_q ? S_E_RD : S_IDLE;
					end else begin
						filt_d  = filt_q + 6'd1;
						state_d = S_RLO;
					end
				end else if (stat.center) begin
					state_d = S_ACC_RD;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.take_div = 1'b1;
					state_d      = S_ACC_RD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_ACC_RD: begin
				cmd.acc_rd = 1'b1;
				state_d    = S_ACC_WR;
			end
			S_ACC_WR: begin
				cmd.acc_wr = 1'b1;
				if (filt_q == hi) begin
					filt_d  = lo;
					state_d = last_q ? S_E_RD : S_IDLE;
				end else begin
					filt_d  = filt_q + 6'd1;
					state_d = S_RLO;
				end
			end
			S_E_RD: begin
				cmd.acc_rd = 1'b1;
				state_d    = S_E_LD;
			end
			S_E_LD: begin
				if (stat.out_free) begin
					cmd.emit_ld = 1'b1;
					if (filt_q == hi) begin
						state_d = S_FIN;
					end else begin
						filt_d  = filt_q + 6'd1;
						state_d = S_E_RD;
					end
				end
			end
			S_FIN: begin
				cmd.frame_clr = 1'b1;
				filt_d        = 6'd1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			filt_q  <= 6'd1;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			filt_q  <= filt_d;
			last_q  <= last_d;
		end
	end

endmodule

FILE: design/mtfb_dp.sv
// ----------------------------------------------------------------------------
// mtfb_dp
// Edge memory, weight multiply, serial divider, accumulators, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtfb_dp import mtfb_pkg::*; #(
	parameter int MAX_FILTERS = 32,
	parameter int MAX_BINS    = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mtfb_in_t   in_data,
	input  mtfb_cmd_t  cmd,
	output mtfb_stat_t stat,
	output logic       out_valid,
	input  logic       out_ready,
	output mtfb_out_t  out_data
);

	localparam int AW_E  = $clog2(MAX_FILTERS + 1);
	localparam int AW_A  = $clog2(MAX_FILTERS);
	localparam int BW    = $clog2(MAX_BINS + 1);
	localparam int POS_W = BW + FRAC_W;
	localparam int PW    = POWER_W + POS_W;
	localparam int CW    = $clog2(PW + 1);

	logic [EDGE_W-1:0]   edge_mem [MAX_FILTERS+1];
	logic [ENERGY_W-1:0] acc_mem  [MAX_FILTERS];
	logic [MAX_FILTERS-1:0] vld_q;

	logic [EDGE_W-1:0]   edge_rd_q;
	logic [ENERGY_W-1:0] acc_rd_q;
	logic                acc_vld_q;
	logic [BW-1:0]       bin_q;
	logic [POS_W-1:0]    pos_q, low_q, mid_q, high_q, dist_q, span_q, rem_q;
	logic [POWER_W-1:0]  power_q, add_q;
	logic [PW-1:0]       dq_q;
	logic [CW-1:0]       cnt_q;
	mtfb_out_t           out_q;
	logic                out_valid_q;

	logic [6:0]          edge_addr7;
	logic [AW_E-1:0]     edge_addr;
	logic [AW_A-1:0]     acc_addr;
	logic [6:0]          wr_idx7;
	logic                rising;
	logic [POS_W:0]      trial;
	logic [ENERGY_W:0]   sum;
	logic [ENERGY_W-1:0] acc_cur;

	assign edge_addr7 = {1'b0, cmd.filt} + {5'd0, cmd.edge_sel} - 7'd2;
	assign edge_addr  = edge_addr7[AW_E-1:0];
	assign acc_addr   = AW_A'(cmd.filt - 6'd1);
	assign wr_idx7    = {1'b0, in_data.edge_index} - 7'd1;

	// Edge memory
	always_ff @(posedge clk) begin
		if (cmd.edge_wr && in_data.edge_index != 6'd0
				&& {1'b0, in_data.edge_index} <= 7'(MAX_FILTERS + 1))
			edge_mem[wr_idx7[AW_E-1:0]] <= in_data.edge_position;
		if (cmd.edge_rd)
			edge_rd_q <= edge_mem[edge_addr];
	end

	// Bin position and power
	assign stat.bins_full = (bin_q == BW'(MAX_BINS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
		end else if (cmd.frame_clr) begin
			bin_q <= '0;
		end else if (cmd.bin_load && !stat.bins_full) begin
			bin_q <= bin_q + BW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bin_load) begin
			pos_q   <= {bin_q + BW'(1), {FRAC_W{1'b0}}};
			power_q <= in_data.power_value;
		end
		if (cmd.cap_low)
			low_q <= cmd.low_zero ? '0 : POS_W'(edge_rd_q);
		if (cmd.cap_mid)
			mid_q <= POS_W'(edge_rd_q);
		if (cmd.cap_high)
			high_q <= POS_W'(edge_rd_q);
	end

	// Triangle classification
	assign stat.skip   = (pos_q <= low_q) || (pos_q >= high_q);
	assign stat.center = (pos_q == mid_q);
	assign rising      = (pos_q < mid_q);

	// Multiply then restoring divide, one quotient bit per cycle
	assign trial         = {rem_q, dq_q[PW-1]};
	assign stat.div_done = (cnt_q == CW'(PW));

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			dist_q <= rising ? pos_q - low_q : high_q - pos_q;
			span_q <= rising ? mid_q - low_q : high_q - mid_q;
			add_q  <= power_q;
		end
		if (cmd.mul) begin
			dq_q  <= {{(PW-POWER_W){1'b0}}, power_q} * {{(PW-POS_W){1'b0}}, dist_q};
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, span_q}) begin
				rem_q <= POS_W'(trial - {1'b0, span_q});
				dq_q  <= {dq_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= trial[POS_W-1:0];
				dq_q  <= {dq_q[PW-2:0], 1'b0};
			end
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.take_div)
			add_q <= dq_q[POWER_W-1:0];
	end

	// Accumulators; an entry without its valid bit reads as zero
	assign acc_cur = acc_vld_q ? acc_rd_q : '0;
	assign sum     = {1'b0, acc_cur} + {{(ENERGY_W-POWER_W+1){1'b0}}, add_q};

	always_ff @(posedge clk) begin
		if (cmd.acc_rd) begin
			acc_rd_q  <= acc_mem[acc_addr];
			acc_vld_q <= vld_q[acc_addr];
		end
		if (cmd.acc_wr)
			acc_mem[acc_addr] <= sum[ENERGY_W] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.frame_clr) begin
			vld_q <= '0;
		end else if (cmd.acc_wr) begin
			vld_q[acc_addr] <= 1'b1;
		end
	end

	// Output register
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_q.filter_energy <= acc_cur;
			out_q.filter_number <= cmd.filt;
			out_q.last_result   <= cmd.last_flag;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: design/mel_triangular_filterbank_top.sv
// ----------------------------------------------------------------------------
// mel_triangular_filterbank_top
// Triangular mel filter bank over one frame of power-spectrum bins.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the start
//    filter (index 0) and filter_count (index 1); always ready, write while idle.
//  - in channel carries mode-0 edge loads (taken while staying idle) and mode-1 bins.
//    Edges 1..MAX_FILTERS+1 must be loaded before bins refer to them.
//  - Per bin, after the accept cycle, each filter of the range is walked in
//    turn: edges read and captured; a filter the bin misses ends there, a
//    centre goes to the accumulate, a slope first to a multiply and the
//    serial restoring divider, which sets the rate. One item in flight at
//    a time; in_ready is high only while the sequencer is idle.
//  - On a last bin, results for the range follow, each read from the
//    accumulators and loaded into the output register, in ascending filter
//    order, last_result on the final one; the frame is then cleared. A
//    stalled receiver holds the output register and the walk.
//  - Reset clears accumulators (per-entry valid bits), bin count and config
//    to start filter 1, filter_count 24. The edge memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mel_triangular_filterbank_top import mtfb_pkg::*; #(
	parameter int MAX_FILTERS = 32,
	parameter int MAX_BINS    = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  mtfb_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output mtfb_out_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data
);

	mtfb_cmd_t  cmd;
	mtfb_stat_t stat;

	// Registers take a write in any cycle
	assign cfg_ready = 1'b1;

	mtfb_ctrl #(
		.MAX_FILTERS(MAX_FILTERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_mode  (in_data.mode),
		.in_last  (in_data.last_bin),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat)
	);

	mtfb_dp #(
		.MAX_FILTERS(MAX_FILTERS),
		.MAX_BINS   (MAX_BINS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

FILE: design/mtfb_checker.sv
// ----------------------------------------------------------------------------
// mtfb_checker
// Port-level checks of the filter bank, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mel_triangular_filterbank_top_macros.svh"

module mtfb_checker import mtfb_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input mtfb_out_t out_data
);

	// A stalled result holds
	`MTFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// No new transfer in while a frame is still being emitted
	`MTFB_ASSERT_IMPL(a_emit_blocks_in, out_valid && !out_data.last_result, !in_ready)

	// A new result never appears while the input side is open
	`MTFB_ASSERT_IMPL(a_rise_blocks_in, $rose(out_valid), !in_ready)

	// Filter numbers start at one
	`MTFB_ASSERT_IMPL(a_fnum_nonzero, out_valid, out_data.filter_number != 6'd0)

endmodule

bind mel_triangular_filterbank_top mtfb_checker u_mtfb_checker (.*);

FILE: dv/tb_mel_triangular_filterbank_top.sv
// ----------------------------------------------------------------------------
// tb_mel_triangular_filterbank_top
// Self-checking bench for the mel filter bank: loads edge tables, streams
// frames of bins under random handshake pressure and compares each filter
// energy against an in-bench triangle-weight accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mel_triangular_filterbank_top;
	import mtfb_pkg::*;

	localparam int NFILT = 32;
	localparam int NBINS = 1024;
	localparam logic [ENERGY_W-1:0] ENERGY_SAT = '1;

	// Expected-energy tracker: mirrors edge table, accumulators and range regs
	class mel_energy_board;
		logic [EDGE_W-1:0]   edge_pos [0:NFILT+1];
		logic [ENERGY_W-1:0] energy [1:NFILT];
		int unsigned         bin_cnt;
		logic [5:0]          first_reg;
		logic [5:0]          count_reg;
		mtfb_out_t           energy_q [$];
		int unsigned         errors;
		int unsigned         matched;
		int unsigned         frames;

		function new();
			foreach (edge_pos[k]) edge_pos[k] = '0;
			foreach (energy[k]) energy[k] = '0;
			bin_cnt = 0;
			first_reg = 6'd1;
			count_reg = 6'd24;
			errors = 0;
			matched = 0;
			frames = 0;
		endfunction

		function void write_reg(logic idx, logic [5:0] val);
			if (idx == CFG_FIRST)
				first_reg = val;
			else
				count_reg = val;
		endfunction

		function int pending();
			return energy_q.size();
		endfunction

		// One accepted input transfer
		function void note_input(mtfb_in_t it);
			int unsigned lo, hi;
			longint unsigned pos, low, mid, high, add, acc;
			mtfb_out_t r;
			if (!it.mode) begin
				if (it.edge_index >= 1 && it.edge_index <= NFILT + 1)
					edge_pos[it.edge_index] = it.edge_position;
				return;
			end
			lo = (first_reg < 1) ? 1 : (first_reg > NFILT) ? NFILT : first_reg;
			hi = lo + ((count_reg < 1) ? 1 : count_reg) - 1;
			if (hi > NFILT) hi = NFILT;
			if (bin_cnt < NBINS) begin
				bin_cnt++;
				pos = longint'(bin_cnt) << FRAC_W;
				for (int f = lo; f <= hi; f++) begin
					low = edge_pos[f-1];
					mid = edge_pos[f];
					high = edge_pos[f+1];
					if (pos <= low || pos >= high) continue;
					if (pos < mid)
						add = (it.power_value * (pos - low)) / (mid - low);
					else if (pos > mid)
						add = (it.power_value * (high - pos)) / (high - mid);
					else
						add = it.power_value;
					acc = energy[f] + add;
					energy[f] = (acc > ENERGY_SAT) ? ENERGY_SAT : acc[ENERGY_W-1:0];
				end
			end
			if (!it.last_bin) return;
			for (int f = lo; f <= hi; f++) begin
				r.filter_energy = energy[f];
				r.filter_number = f[FNUM_W-1:0];
				r.last_result = (f == hi);
				energy_q.push_back(r);
			end
			foreach (energy[k]) energy[k] = '0;
			bin_cnt = 0;
			frames++;
		endfunction

		// One accepted output transfer
		function void check_result(mtfb_out_t got);
			mtfb_out_t want;
			if (energy_q.size() == 0) begin
				$display("%0t: unexpected result energy=%0d filter=%0d last=%0b",
					$time, got.filter_energy, got.filter_number, got.last_result);
				errors++;
				return;
			end
			want = energy_q.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch exp energy=%0d filter=%0d last=%0b", $time,
					want.filter_energy, want.filter_number, want.last_result);
				$display("%0t:          got energy=%0d filter=%0d last=%0b", $time,
					got.filter_energy, got.filter_number, got.last_result);
				errors++;
			end else
				matched++;
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	mtfb_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	mtfb_out_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = CFG_FIRST;
	logic [5:0] cfg_data = '0;

	mel_energy_board board = new();

	// Handshake shaping knobs, shared between stimulus and receiver
	bit          sender_steady = 1'b0;
	bit          recv_steady = 1'b0;
	int unsigned recv_hold = 0;
	int unsigned burst_left = 0;

	always #6 clk = ~clk;

	mel_triangular_filterbank_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Receiver: long hold-offs when requested, otherwise random or steady ready
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold--;
		end else if (recv_steady)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	// Output monitor
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);

	// Hard stop in case the pipeline wedges
	initial begin
		#20ms;
		$display("Timeout with %0d results outstanding", board.pending());
		$display("Regression FAIL");
		$finish;
	end

	// Drive one input transfer; valid stays up for a following send
	task automatic send_item(mtfb_in_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		board.note_input(it);
		// Bursty sender: drop valid for a random gap between bursts
		if (!sender_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 10);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 14)) @(negedge clk);
			end else
				burst_left--;
		end
	endtask

	task automatic load_edge(int idx, logic [EDGE_W-1:0] pos);
		mtfb_in_t it;
		it = '0;
		it.mode = 1'b0;
		it.edge_index = idx[FNUM_W-1:0];
		it.edge_position = pos;
		it.power_value = $urandom;
		it.last_bin = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	task automatic send_bin(logic [POWER_W-1:0] pwr, bit last);
		mtfb_in_t it;
		it.mode = 1'b1;
		it.edge_index = FNUM_W'($urandom);
		it.edge_position = EDGE_W'($urandom);
		it.power_value = pwr;
		it.last_bin = last;
		send_item(it);
	endtask

	task automatic send_frame(int nbins, bit full_power);
		for (int b = 1; b <= nbins; b++)
			send_bin(full_power ? $urandom : $urandom_range(0, 1000), b == nbins);
	endtask

	// Drain outstanding results, then cover any in-flight walk
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [5:0] val);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_range(logic [5:0] first, logic [5:0] cnt);
		write_cfg(CFG_FIRST, first);
		write_cfg(CFG_COUNT, cnt);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: edge on every bin, so each bin sits exactly on a centre
		sender_steady = 1'b1;
		recv_steady = 1'b1;
		for (int k = 1; k <= NFILT + 1; k++)
			load_edge(k, EDGE_W'(k * 64));
		send_bin('1, 1'b1);               // single-bin frame, max power
		send_bin('0, 1'b0);               // zero power
		send_bin(32'hFFFF_FFFF, 1'b0);
		send_bin(32'h8000_0001, 1'b1);

		// Directed: fractional edges so bins fall on both slopes
		load_edge(1, 17'd40);
		load_edge(2, 17'd150);
		load_edge(3, 17'd300);
		load_edge(0, 17'h1FFFF);          // out-of-range index, ignored
		load_edge(63, 17'h1FFFF);         // out-of-range index, ignored
		load_edge(34, 17'd5);             // out-of-range index, ignored
		send_frame(5, 1'b1);

		// Disordered edges: centre below low, high below centre
		load_edge(1, 17'd500);
		load_edge(2, 17'd100);
		load_edge(3, 17'h1FFFF);
		send_frame(4, 1'b1);

		// Range extremes, including clamped register values
		set_range(6'd32, 6'd32);
		send_frame(3, 1'b1);
		set_range(6'd0, 6'd0);
		send_frame(2, 1'b1);
		set_range(6'd63, 6'd63);
		send_frame(2, 1'b1);
		set_range(6'd1, 6'd32);
		send_frame(3, 1'b1);

		// Back-pressure: receiver stalls long while frames keep coming
		set_range(6'd1, 6'd32);
		sender_steady = 1'b0;
		recv_steady = 1'b0;
		recv_hold = 3000;
		send_frame(2, 1'b1);
		send_frame(3, 1'b1);
		wait_drained();

		// Random frames over random ranges and edge rewrites
		for (int ph = 0; ph < 4; ph++) begin
			set_range(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			sender_steady = (ph == 1);
			recv_steady = (ph == 2);
			// Stray edge writes, in range or not
			repeat (4) begin
				if ($urandom_range(0, 1) == 0)
					load_edge($urandom_range(0, 63), EDGE_W'($urandom_range(0, 1200)));
				else
					load_edge($urandom_range(0, 63), EDGE_W'($urandom));
			end
			for (int fr = 0; fr < 2; fr++)
				send_frame($urandom_range(1, 4), $urandom_range(0, 3) != 0);
		end

		wait_drained();
		$display("Covered %0d frames, %0d filter energies checked, %0d errors",
			board.frames, board.matched, board.errors);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/mtfb_pkg.sv
design/mtfb_ctrl.sv
design/mtfb_dp.sv
design/mel_triangular_filterbank_top.sv
design/mtfb_checker.sv
dv/tb_mel_triangular_filterbank_top.sv
